/* hdl/voxel_ray_traversal_core_assert.svh */
// Assertion macros used by voxel_ray_traversal_core.sv.
`ifndef VOXEL_RAY_TRAVERSAL_CORE_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/vrt_pkg.sv */
package vrt_pkg;

    localparam int INDEX_BITS     = 16;
    localparam int TIME_FRAC_BITS = 24;
    localparam int TIME_BITS      = 48;
    localparam int LEFT_BITS      = 18;
    localparam int DIV_BITS       = 64;
    localparam int DEN_BITS       = 33;
    localparam int CNT_BITS       = 6;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [LEFT_BITS-1:0] LEFT_MAX = {LEFT_BITS{1'b1}};

    localparam logic [2:0] REG_CELL_SIZE  = 3'd0;
    localparam logic [2:0] REG_GRID_MIN_X = 3'd1;
    localparam logic [2:0] REG_GRID_MIN_Y = 3'd2;
    localparam logic [2:0] REG_GRID_MIN_Z = 3'd3;
    localparam logic [2:0] REG_NUM_DIMS   = 3'd4;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    localparam logic [1:0] DIMS_PLANAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_IDX_START,
        OP_IDX_STOP,
        OP_BORDER,
        OP_INCR
    } op_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DEN_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
        logic [DEN_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

/* hdl/vrt_div.sv */
module vrt_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  vrt_pkg::div_req_t req,
    output vrt_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [vrt_pkg::CNT_BITS-1:0]      cnt_reg;
    logic [vrt_pkg::DIV_BITS-1:0]      quo_reg;
    logic [vrt_pkg::DEN_BITS-1:0]      rem_reg;
    logic [vrt_pkg::DEN_BITS-1:0]      den_reg;
    logic [vrt_pkg::DEN_BITS:0]        trial;
    logic                              fits;
    logic [vrt_pkg::DEN_BITS:0]        diff;
    logic [vrt_pkg::DEN_BITS-1:0]      rem_next;
    logic [vrt_pkg::DIV_BITS-1:0]      quo_next;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        trial    = {rem_reg, quo_reg[vrt_pkg::DIV_BITS-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[vrt_pkg::DEN_BITS-1:0] : trial[vrt_pkg::DEN_BITS-1:0];
        quo_next = {quo_reg[vrt_pkg::DIV_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vrt_pkg::CNT_BITS'(vrt_pkg::DIV_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* hdl/voxel_ray_traversal_core.sv */
// Channel   Direction  Ports
// input     in         s_valid, s_ready, s_action, s_start_*, s_stop_*
// result    out        m_valid, m_ready, m_cell_*, m_last_cell, m_valid_res
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
// For an advance word the min-compare and add happen on acceptance.
// A load word runs two to four divisions per axis on one shared serial divider,
// one after another, over three axes in volume mode; planar loads walk two axes.
// Reset (aresetn low, synchronous) clears the ray and restores the default
// configuration.
// A waiting result does not block a new word when m_ready is high that cycle.
`include "voxel_ray_traversal_core_assert.svh"

module voxel_ray_traversal_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_start_x,
    input  logic [31:0] s_start_y,
    input  logic [31:0] s_start_z,
    input  logic [31:0] s_stop_x,
    input  logic [31:0] s_stop_y,
    input  logic [31:0] s_stop_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_cell_x,
    output logic [15:0] m_cell_y,
    output logic [15:0] m_cell_z,
    output logic        m_last_cell,
    output logic        m_valid_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IB = vrt_pkg::INDEX_BITS;
    localparam int TB = vrt_pkg::TIME_BITS;
    localparam int LB = vrt_pkg::LEFT_BITS;

    vrt_pkg::state_t state_reg, state_next;
    vrt_pkg::op_t    op_reg, op_next;
    logic [1:0]      axis_reg, axis_next;

    logic [30:0]        size_cfg_reg;
    logic signed [31:0] gmin_reg [3];
    logic [1:0]         dims_reg;

    logic signed [31:0] start_reg [3];
    logic signed [31:0] stop_reg [3];

    logic [IB-1:0]  cell_reg [3];
    logic [1:0]     sign_reg [3];
    logic [TB-1:0]  border_reg [3];
    logic [TB-1:0]  incr_reg [3];
    logic [LB-1:0]  left_reg;
    logic           active_reg;

    logic signed [34:0] is_reg;
    logic [30:0]        rs_reg;
    logic [36:0]        dist_reg;

    logic        m_valid_reg;
    logic [15:0] out_x_reg, out_y_reg, out_z_reg;
    logic        out_last_reg, out_vres_reg;

    vrt_pkg::div_req_t div_req;
    vrt_pkg::div_rsp_t div_rsp;

    logic               accept;
    logic               planar;
    logic [1:0]         last_axis;
    logic [30:0]        size;
    logic signed [32:0] vs, ve, dir, vcur;
    logic [32:0]        vabs, dabs;
    logic [33:0]        qa;
    logic [30:0]        ra;
    logic signed [34:0] fq;
    logic [30:0]        frem;
    logic signed [35:0] dd;
    logic [35:0]        ddabs;
    logic [TB-1:0]      qsat;
    logic [1:0]         a_sel;
    logic [TB:0]        bsum;
    logic [LB-1:0]      left_dec;

    vrt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign planar    = dims_reg == vrt_pkg::DIMS_PLANAR;
    assign last_axis = planar ? 2'd1 : 2'd2;
    assign size      = (size_cfg_reg == '0) ? 31'd1 : size_cfg_reg;

    // Operands for the axis being loaded.
    always_comb begin
        vs    = 33'(start_reg[axis_reg]) - 33'(gmin_reg[axis_reg]);
        ve    = 33'(stop_reg[axis_reg]) - 33'(gmin_reg[axis_reg]);
        dir   = 33'(stop_reg[axis_reg]) - 33'(start_reg[axis_reg]);
        vcur  = (op_reg == vrt_pkg::OP_IDX_START) ? vs : ve;
        vabs  = vcur[32] ? 33'(-vcur) : 33'(vcur);
        dabs  = dir[32] ? 33'(-dir) : 33'(dir);
        qa    = div_rsp.quotient[33:0];
        ra    = div_rsp.remainder[30:0];
        // Floor division from the magnitude result.
        if (vcur[32]) begin
            fq   = -$signed({1'b0, qa}) - 35'(ra != '0);
            frem = (ra != '0) ? 31'(size - ra) : '0;
        end else begin
            fq   = $signed({1'b0, qa});
            frem = ra;
        end
        dd    = 36'(fq) - 36'(is_reg);
        ddabs = dd[35] ? 36'(-dd) : 36'(dd);
        qsat  = (div_rsp.quotient[vrt_pkg::DIV_BITS-1:TB] != '0) ? vrt_pkg::TIME_MAX
                                                               : div_rsp.quotient[TB-1:0];
    end

    // Axis selection for an advance; ties go to the later axis.
    always_comb begin
        if (planar) begin
            a_sel = (border_reg[0] < border_reg[1]) ? 2'd0 : 2'd1;
        end else if (border_reg[0] < border_reg[1]) begin
            a_sel = (border_reg[0] < border_reg[2]) ? 2'd0 : 2'd2;
        end else begin
            a_sel = (border_reg[1] < border_reg[2]) ? 2'd1 : 2'd2;
        end
        bsum     = {1'b0, border_reg[a_sel]} + {1'b0, incr_reg[a_sel]};
        left_dec = left_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vrt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        axis_next        = axis_reg;
        div_req.start    = 1'b0;
        div_req.dividend = 64'(vabs);
        div_req.divisor  = 33'(size);
        s_ready          = 1'b0;
        case (op_reg)
            vrt_pkg::OP_BORDER: begin
                div_req.dividend = 64'(dir[32] ? rs_reg : 31'(size - rs_reg))
                                   << vrt_pkg::TIME_FRAC_BITS;
                div_req.divisor  = dabs;
            end
            vrt_pkg::OP_INCR: begin
                div_req.dividend = 64'(size) << vrt_pkg::TIME_FRAC_BITS;
                div_req.divisor  = dabs;
            end
            default: begin
            end
        endcase
        case (state_reg)
            vrt_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (accept && !s_action) begin
                    state_next = vrt_pkg::ST_LOAD;
                    op_next    = vrt_pkg::OP_IDX_START;
                    axis_next  = 2'd0;
                end
            end
            vrt_pkg::ST_LOAD: begin
                div_req.start = 1'b1;
                state_next    = vrt_pkg::ST_WAIT;
            end
            vrt_pkg::ST_WAIT: begin
                if (div_rsp.done) begin
                    state_next = vrt_pkg::ST_LOAD;
                    case (op_reg)
                        vrt_pkg::OP_IDX_START: op_next = vrt_pkg::OP_IDX_STOP;
                        vrt_pkg::OP_BORDER:    op_next = vrt_pkg::OP_INCR;
                        default: begin
                            if (op_reg == vrt_pkg::OP_IDX_STOP && dir != '0) begin
                                op_next = vrt_pkg::OP_BORDER;
                            end else if (axis_reg == last_axis) begin
                                state_next = vrt_pkg::ST_FIN;
                            end else begin
                                axis_next = axis_reg + 1'b1;
                                op_next   = vrt_pkg::OP_IDX_START;
                            end
                        end
                    endcase
                end
            end
            vrt_pkg::ST_FIN: begin
                state_next = vrt_pkg::ST_IDLE;
            end
            default: begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg       <= vrt_pkg::OP_IDX_START;
            axis_reg     <= 2'd0;
            size_cfg_reg <= 31'd65536;
            dims_reg     <= 2'd3;
            m_valid_reg  <= 1'b0;
            left_reg     <= '0;
            active_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                gmin_reg[i]   <= '0;
                cell_reg[i]   <= '0;
                sign_reg[i]   <= vrt_pkg::SIGN_NONE;
                border_reg[i] <= vrt_pkg::TIME_MAX;
                incr_reg[i]   <= vrt_pkg::TIME_MAX;
            end
        end else begin
            op_reg   <= op_next;
            axis_reg <= axis_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vrt_pkg::REG_CELL_SIZE:  size_cfg_reg <= cfg_data[30:0];
                    vrt_pkg::REG_GRID_MIN_X: gmin_reg[0]  <= cfg_data;
                    vrt_pkg::REG_GRID_MIN_Y: gmin_reg[1]  <= cfg_data;
                    vrt_pkg::REG_GRID_MIN_Z: gmin_reg[2]  <= cfg_data;
                    vrt_pkg::REG_NUM_DIMS:   dims_reg     <= cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && !s_action) begin
                dist_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    cell_reg[i]   <= '0;
                    sign_reg[i]   <= vrt_pkg::SIGN_NONE;
                    border_reg[i] <= vrt_pkg::TIME_MAX;
                    incr_reg[i]   <= vrt_pkg::TIME_MAX;
                end
            end else if (accept) begin
                m_valid_reg <= 1'b1;
                if (!active_reg) begin
                    out_x_reg    <= '0;
                    out_y_reg    <= '0;
                    out_z_reg    <= '0;
                    out_last_reg <= 1'b0;
                    out_vres_reg <= 1'b0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) == a_sel) begin
                            if (sign_reg[i] == vrt_pkg::SIGN_POS) begin
                                cell_reg[i] <= cell_reg[i] + 1'b1;
                            end else if (sign_reg[i] == vrt_pkg::SIGN_NEG) begin
                                cell_reg[i] <= cell_reg[i] - 1'b1;
                            end
                        end
                    end
                    out_x_reg <= 16'(cell_reg[0]);
                    out_y_reg <= 16'(cell_reg[1]);
                    out_z_reg <= 16'(cell_reg[2]);
                    case (a_sel)
                        2'd0:    out_x_reg <= 16'(cell_reg[0] + IB'(sign_reg[0] == vrt_pkg::SIGN_POS)
                                                  - IB'(sign_reg[0] == vrt_pkg::SIGN_NEG));
                        2'd1:    out_y_reg <= 16'(cell_reg[1] + IB'(sign_reg[1] == vrt_pkg::SIGN_POS)
                                                  - IB'(sign_reg[1] == vrt_pkg::SIGN_NEG));
                        default: out_z_reg <= 16'(cell_reg[2] + IB'(sign_reg[2] == vrt_pkg::SIGN_POS)
                                                  - IB'(sign_reg[2] == vrt_pkg::SIGN_NEG));
                    endcase
                    border_reg[a_sel] <= bsum[TB] ? vrt_pkg::TIME_MAX : bsum[TB-1:0];
                    left_reg     <= left_dec;
                    active_reg   <= left_dec != '0;
                    out_last_reg <= left_dec == '0;
                    out_vres_reg <= 1'b1;
                end
            end
            if (state_reg == vrt_pkg::ST_WAIT && div_rsp.done) begin
                case (op_reg)
                    vrt_pkg::OP_IDX_START: begin
                        is_reg <= fq;
                        rs_reg <= frem;
                    end
                    vrt_pkg::OP_IDX_STOP: begin
                        dist_reg           <= dist_reg + 37'(ddabs);
                        cell_reg[axis_reg] <= is_reg[IB-1:0];
                        if (dir != '0) begin
                            sign_reg[axis_reg] <= dir[32] ? vrt_pkg::SIGN_NEG : vrt_pkg::SIGN_POS;
                        end
                    end
                    vrt_pkg::OP_BORDER: border_reg[axis_reg] <= qsat;
                    default:            incr_reg[axis_reg]   <= qsat;
                endcase
            end
            if (state_reg == vrt_pkg::ST_FIN) begin
                m_valid_reg  <= 1'b1;
                left_reg     <= (dist_reg > 37'(vrt_pkg::LEFT_MAX)) ? vrt_pkg::LEFT_MAX
                                                                   : dist_reg[LB-1:0];
                active_reg   <= dist_reg != '0;
                out_x_reg    <= 16'(cell_reg[0]);
                out_y_reg    <= 16'(cell_reg[1]);
                out_z_reg    <= 16'(cell_reg[2]);
                out_last_reg <= dist_reg == '0;
                out_vres_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            start_reg[0] <= s_start_x;
            start_reg[1] <= s_start_y;
            start_reg[2] <= s_start_z;
            stop_reg[0]  <= s_stop_x;
            stop_reg[1]  <= s_stop_y;
            stop_reg[2]  <= s_stop_z;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cell_x    = out_x_reg;
    assign m_cell_y    = out_y_reg;
    assign m_cell_z    = out_z_reg;
    assign m_last_cell = out_last_reg;
    assign m_valid_res = out_vres_reg;

    `VRT_ASSERT_SAME(a_ready_idle, aclk, aresetn, s_ready, state_reg == vrt_pkg::ST_IDLE)
    `VRT_ASSERT_SAME(a_active_left, aclk, aresetn, 1'b1, active_reg == (left_reg != '0))
    `VRT_ASSERT_SAME(a_fin_out_free, aclk, aresetn, state_reg == vrt_pkg::ST_FIN, !m_valid_reg)
    `VRT_ASSERT_NEXT(a_load_waits, aclk, aresetn, state_reg == vrt_pkg::ST_LOAD,
                     state_reg == vrt_pkg::ST_WAIT)

endmodule
